FILE: rtl/core/ordm_pkg.sv
// Shared types, constants and the sequencer program for the optical read delay core.
// No dependencies; imported by ordm_div and optical_read_delay_model_core.
`default_nettype none

package ordm_pkg;

    // Speed curve constants: time per sector = K1 / (K2 + sector)
    localparam logic [31:0] CD_K1           = 32'd317142857;
    localparam logic [31:0] CD_K2           = 32'd237857;
    localparam logic [31:0] CD_FLOOR        = 32'd644;
    localparam logic [31:0] DL_K1           = 32'd1323784126;
    localparam logic [31:0] DL_K2           = 32'd1489257;
    localparam logic [31:0] SL_K1           = 32'd1459362539;
    localparam logic [31:0] SL_K2           = 32'd1641782;
    localparam logic [31:0] CLOCKS_PER_USEC = 32'd37;

    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
    localparam int unsigned STEP_W    = 4;

    // Register map (word index)
    localparam logic REG_MEDIA_IS_CD        = 1'b0;
    localparam logic REG_SECOND_LAYER_START = 1'b1;

    typedef logic [STEP_W-1:0] t_step;

    // Program addresses
    localparam t_step STEP_IDLE   = 4'd0;
    localparam t_step STEP_EFF    = 4'd1;
    localparam t_step STEP_LOAD   = 4'd2;
    localparam t_step STEP_DIV    = 4'd3;
    localparam t_step STEP_FLOOR  = 4'd4;
    localparam t_step STEP_MUL1   = 4'd5;
    localparam t_step STEP_MUL2   = 4'd6;
    localparam t_step STEP_AHEAD  = 4'd7;
    localparam t_step STEP_SUB    = 4'd8;
    localparam t_step STEP_WAIT   = 4'd9;
    localparam t_step STEP_DONE   = 4'd10;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_EFF,
        OP_LOAD,
        OP_DIV,
        OP_FLOOR,
        OP_MUL1,
        OP_MUL2,
        OP_AHEAD,
        OP_SUB,
        OP_DONE
    } t_op;

    typedef enum logic [2:0] {
        J_NONE,
        J_ALWAYS,
        J_NO_IN,
        J_DIV_MORE,
        J_OUT_BUSY
    } t_jmp;

    typedef struct packed {
        t_op   op;
        t_jmp  jmp;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

    // Control store: a taken jump goes to target, otherwise fall through
    function automatic t_uword f_urom(input t_step step);
        t_uword w;
        w = '{op: OP_NOP, jmp: J_ALWAYS, target: STEP_IDLE};
        case (step)
            STEP_IDLE:  w = '{op: OP_NOP,   jmp: J_NO_IN,    target: STEP_IDLE};
            STEP_EFF:   w = '{op: OP_EFF,   jmp: J_NONE,     target: STEP_IDLE};
            STEP_LOAD:  w = '{op: OP_LOAD,  jmp: J_NONE,     target: STEP_IDLE};
            STEP_DIV:   w = '{op: OP_DIV,   jmp: J_DIV_MORE, target: STEP_DIV};
            STEP_FLOOR: w = '{op: OP_FLOOR, jmp: J_NONE,     target: STEP_IDLE};
            STEP_MUL1:  w = '{op: OP_MUL1,  jmp: J_NONE,     target: STEP_IDLE};
            STEP_MUL2:  w = '{op: OP_MUL2,  jmp: J_NONE,     target: STEP_IDLE};
            STEP_AHEAD: w = '{op: OP_AHEAD, jmp: J_NONE,     target: STEP_IDLE};
            STEP_SUB:   w = '{op: OP_SUB,   jmp: J_NONE,     target: STEP_IDLE};
            STEP_WAIT:  w = '{op: OP_NOP,   jmp: J_OUT_BUSY, target: STEP_WAIT};
            STEP_DONE:  w = '{op: OP_DONE,  jmp: J_ALWAYS,   target: STEP_IDLE};
            default:    w = '{op: OP_NOP,   jmp: J_ALWAYS,   target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/optical_read_delay_model_core.sv
// Read delay model for a constant-angular-velocity optical disc: top level.
// Depends on ordm_pkg and ordm_div.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one word per read request:
//   start sector, sector count and the current 64-bit clock. Output channel
//   (o_out_valid / i_out_ready) returns one word per request: the delay in
//   clock ticks, modulo 2^32. Configuration (media type, second layer start)
//   goes through the APB-style port and is to be written only while idle;
//   the block itself does not enforce this. A small microprogram drives the
//   datapath. Each request runs from acceptance through 2 set-up steps, the
//   bit-serial divider that produces the time per sector, then 7 steps of
//   floor, multiply, compare, wait for the output register and update.
//   A new request is taken only once the sequencer is back at its idle step.
//   If the receiver stalls, the finished result is held in the output
//   register; the next request may still be computed, and it waits at its
//   wait step, before its final step, until that register is free.
//   Reset (synchronous, active low) clears the configuration registers, the
//   expected next sector, the last read end clock and the output valid flag,
//   and returns the sequencer to idle.
`default_nettype none

module optical_read_delay_model_core
    import ordm_pkg::*;
#(
    parameter int unsigned READ_AHEAD_SECTORS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_start_sector,
    input  wire logic [15:0] i_sector_count,
    input  wire logic [63:0] i_now_clock,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_delay_clocks,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [31:0] RA_MULT = 32'(READ_AHEAD_SECTORS);

    // configuration and persistent state
    logic        r_media_cd;
    logic [31:0] r_layer_start;
    logic [63:0] r_read_end;
    logic [31:0] r_expected;

    // sequencer
    t_step       r_step;
    t_step       n_step;
    t_uword      w_uw;
    logic        w_jump;
    logic        w_in_acc;
    logic        w_out_free;

    // datapath
    logic [31:0] r_sector;
    logic [15:0] r_count;
    logic [63:0] r_now;
    logic [31:0] r_eff;
    logic [31:0] r_k1;
    logic [31:0] r_k2;
    logic [31:0] r_per;
    logic [31:0] r_prod;
    logic [31:0] r_pc37;
    logic [31:0] r_delay;
    logic [31:0] r_cap;
    logic [31:0] r_ahead;
    logic        r_seq;
    logic        r_out_valid;
    logic [31:0] r_out_data;

    logic [63:0] w_base;
    logic [31:0] w_elapsed;
    t_div_ctl    w_div_ctl;
    logic [31:0] w_quo;
    logic        w_div_last;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SECOND_LAYER_START) ? r_layer_start
                                                         : {31'b0, r_media_cd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_media_cd    <= 1'b0;
            r_layer_start <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_MEDIA_IS_CD:        r_media_cd    <= pwdata[0];
                REG_SECOND_LAYER_START: r_layer_start <= pwdata;
                default:                r_media_cd    <= r_media_cd;
            endcase
        end
    end

    // ---------------------------------------------------------------- sequencer
    assign w_uw       = f_urom(r_step);
    assign o_in_ready = r_step == STEP_IDLE;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (w_uw.jmp)
            J_NONE:     w_jump = 1'b0;
            J_ALWAYS:   w_jump = 1'b1;
            J_NO_IN:    w_jump = !w_in_acc;
            J_DIV_MORE: w_jump = !w_div_last;
            J_OUT_BUSY: w_jump = !w_out_free;
            default:    w_jump = 1'b1;
        endcase
        n_step = w_jump ? w_uw.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // ---------------------------------------------------------------- divider
    assign w_div_ctl.load = w_uw.op == OP_LOAD;
    assign w_div_ctl.step = w_uw.op == OP_DIV;

    ordm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (r_k1),
        .i_den   (r_eff + r_k2),
        .o_quo   (w_quo),
        .o_last  (w_div_last)
    );

    // ---------------------------------------------------------------- datapath
    // A zero last end clock counts as "now", so the first read gets no credit
    assign w_base    = (r_read_end == 64'd0) ? r_now : r_read_end;
    assign w_elapsed = r_now[31:0] - w_base[31:0];

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sector <= i_start_sector;
            r_count  <= i_sector_count;
            r_now    <= i_now_clock;
        end
        case (w_uw.op)
            OP_EFF: begin
                if (r_media_cd) begin
                    r_eff <= r_sector;
                    r_k1  <= CD_K1;
                    r_k2  <= CD_K2;
                end else if (r_layer_start != 32'd0) begin
                    // rebase sectors on the second layer
                    r_eff <= (r_sector >= r_layer_start) ? r_sector - r_layer_start
                                                         : r_sector;
                    r_k1  <= DL_K1;
                    r_k2  <= DL_K2;
                end else begin
                    r_eff <= r_sector;
                    r_k1  <= SL_K1;
                    r_k2  <= SL_K2;
                end
            end
            OP_FLOOR: begin
                r_per <= (r_media_cd && w_quo < CD_FLOOR) ? CD_FLOOR : w_quo;
            end
            OP_MUL1: begin
                r_prod <= r_per * 32'(r_count);
                r_pc37 <= r_per * CLOCKS_PER_USEC;
            end
            OP_MUL2: begin
                r_delay <= r_prod * CLOCKS_PER_USEC;
                r_cap   <= r_pc37 * RA_MULT;
            end
            OP_AHEAD: begin
                r_ahead <= (w_elapsed > r_cap) ? r_cap : w_elapsed;
                r_seq   <= r_sector == r_expected;
            end
            OP_SUB: begin
                // floor at zero
                if (r_seq) begin
                    r_delay <= (r_delay < r_ahead) ? 32'd0 : r_delay - r_ahead;
                end
            end
            default: begin
                r_per <= r_per;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_end  <= '0;
            r_expected  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_uw.op == OP_DONE) begin
                r_out_valid <= 1'b1;
                r_expected  <= r_sector + 32'(r_count);
                r_read_end  <= r_now + 64'(r_delay);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uw.op == OP_DONE) begin
            r_out_data <= r_delay;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_delay_clocks = r_out_data;

    // ---------------------------------------------------------------- checks
    a_rise_after_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_uw.op == OP_DONE))
        else $error("result word appeared without a completion step");

    a_accept_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_step == STEP_EFF)
        else $error("accepted request did not start the program");

    a_floor_after_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_FLOOR) |-> $past(w_div_last) && $past(r_step == STEP_DIV))
        else $error("divider left before its last iteration");

    a_done_only_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uw.op == OP_DONE) |-> w_out_free)
        else $error("result overwrote a word still waiting");

endmodule

`default_nettype wire

FILE: rtl/core/ordm_div.sv
// Restoring 32-bit divider, one quotient bit per cycle, driven by the sequencer.
// Depends on ordm_pkg for the control struct and step count.
`default_nettype none

module ordm_div
    import ordm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_div_ctl    i_ctl,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic [31:0]      o_quo,
    output logic             o_last
);

    logic [31:0]      r_quo;
    logic [31:0]      r_rem;
    logic [31:0]      r_den;
    logic [CNT_W-1:0] r_cnt;
    logic [32:0]      w_trial;
    logic             w_fit;

    // A zero divisor always fits, which yields all ones
    assign w_trial = {r_rem, r_quo[31]};
    assign w_fit   = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= '0;
        end else if (i_ctl.step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (i_ctl.step) begin
            r_quo <= {r_quo[30:0], w_fit};
            r_rem <= w_fit ? 32'(w_trial - {1'b0, r_den}) : w_trial[31:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_last = r_cnt == CNT_W'(DIV_STEPS - 1);

endmodule

`default_nettype wire

FILE: sim/ordm_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the optical read delay core: predicts the delay of every accepted request,
// checks each returned word and each register read. Depends on ordm_pkg for curves and map.

module ordm_checker
    import ordm_pkg::*;
#(
    parameter int unsigned READ_AHEAD = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [31:0] i_start_sector,
    input  wire logic [15:0] i_sector_count,
    input  wire logic [63:0] i_now_clock,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [31:0] i_delay_clocks,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic [31:0] i_prdata,
    input  wire logic        i_pready,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_credited
);

    logic        cd_curve;
    logic [31:0] layer_start;
    logic [31:0] next_sector;
    logic [63:0] last_end_clock;
    logic [31:0] delay_due[$];

    int fail_count = 0;
    int checked    = 0;
    int credited   = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;
    assign o_credited   = credited;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ordm_checker: %s got %08h want %08h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : scoreboard
        logic [31:0] dividend;
        logic [31:0] divisor;
        logic [31:0] eff_sector;
        logic [31:0] per_sector;
        logic [31:0] delay;
        logic [31:0] credit;
        logic [31:0] credit_cap;
        logic [31:0] due;
        logic [63:0] elapsed;
        if (!i_rst_n) begin
            cd_curve       = 1'b0;
            layer_start    = '0;
            next_sector    = '0;
            last_end_clock = '0;
            delay_due.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr == {REG_MEDIA_IS_CD, 2'b00})
                        cd_curve = i_pwdata[0];
                    else if (i_paddr == {REG_SECOND_LAYER_START, 2'b00})
                        layer_start = i_pwdata;
                end else if (i_paddr == {REG_MEDIA_IS_CD, 2'b00}) begin
                    if (i_prdata !== {31'd0, cd_curve})
                        report_mismatch("media_is_cd read", i_prdata, {31'd0, cd_curve});
                end else if (i_paddr == {REG_SECOND_LAYER_START, 2'b00}) begin
                    if (i_prdata !== layer_start)
                        report_mismatch("second_layer_start read", i_prdata, layer_start);
                end
            end

            // retire before predicting: a word leaving now belongs to an older request
            if (i_out_valid && i_out_ready) begin
                if (delay_due.size() == 0) begin
                    report_mismatch("delay word with none expected", i_delay_clocks, 32'd0);
                end else begin
                    due = delay_due.pop_front();
                    checked++;
                    if (i_delay_clocks !== due)
                        report_mismatch("delay_clocks", i_delay_clocks, due);
                end
            end

            if (i_in_valid && i_in_ready) begin
                if (cd_curve) begin
                    dividend = CD_K1;
                    divisor  = CD_K2 + i_start_sector;
                end else if (layer_start != 0) begin
                    // rebase sectors on the second layer to its start
                    eff_sector = (i_start_sector >= layer_start) ?
                                 i_start_sector - layer_start : i_start_sector;
                    dividend   = DL_K1;
                    divisor    = DL_K2 + eff_sector;
                end else begin
                    dividend = SL_K1;
                    divisor  = SL_K2 + i_start_sector;
                end
                // a wrapped-to-zero divisor yields all ones; the CD floor leaves that alone
                per_sector = (divisor == 0) ? 32'hFFFF_FFFF : dividend / divisor;
                if (cd_curve && per_sector < CD_FLOOR)
                    per_sector = CD_FLOOR;
                delay = per_sector * i_sector_count * CLOCKS_PER_USEC;

                if (last_end_clock == 0)
                    last_end_clock = i_now_clock;
                if (i_start_sector == next_sector) begin
                    elapsed    = i_now_clock - last_end_clock;
                    credit     = elapsed[31:0];
                    credit_cap = per_sector * CLOCKS_PER_USEC * READ_AHEAD;
                    if (credit > credit_cap)
                        credit = credit_cap;
                    delay = (delay < credit) ? 32'd0 : delay - credit;
                    credited++;
                end
                next_sector    = i_start_sector + i_sector_count;
                last_end_clock = i_now_clock + {32'd0, delay};
                delay_due.push_back(delay);
            end
        end
        o_pending <= delay_due.size();
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for optical_read_delay_model_core: clock, reset, register set-up, request
// and result traffic, verdict. Depends on ordm_pkg, the core and ordm_checker.

module tb_top
    import ordm_pkg::*;
();

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 200;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_start_sector = '0;
    logic [15:0] i_sector_count = '0;
    logic [63:0] i_now_clock    = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [31:0] o_delay_clocks;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;
    int credited;
    int quiet_cycles = 0;
    int sent         = 0;
    int settings_run = 0;

    // stimulus bookkeeping: sequential sectors, request clocks, layer start and pacing
    logic [31:0] next_sector     = '0;
    logic [63:0] req_clock       = '0;
    logic [31:0] layer_start_cfg = '0;
    bit          steady_send     = 1'b0;
    bit          steady_take     = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    optical_read_delay_model_core #(
        .READ_AHEAD_SECTORS(16)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_start_sector (i_start_sector),
        .i_sector_count (i_sector_count),
        .i_now_clock    (i_now_clock),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_delay_clocks (o_delay_clocks),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    ordm_checker #(
        .READ_AHEAD(16)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_start_sector (i_start_sector),
        .i_sector_count (i_sector_count),
        .i_now_clock    (i_now_clock),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_delay_clocks (o_delay_clocks),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_credited     (credited)
    );

    task automatic apb_access(input bit is_write, input logic reg_idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_media(input logic cd, input logic [31:0] layer_start);
        apb_access(1'b1, REG_MEDIA_IS_CD, {31'd0, cd});
        apb_access(1'b1, REG_SECOND_LAYER_START, layer_start);
        apb_access(1'b0, REG_MEDIA_IS_CD, 32'd0);
        apb_access(1'b0, REG_SECOND_LAYER_START, 32'd0);
        layer_start_cfg = layer_start;
        settings_run++;
    endtask

    task automatic send_request(input logic [31:0] sector, input logic [15:0] count,
                                input logic [63:0] now);
        int gap;
        gap = steady_send ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_start_sector <= sector;
        i_sector_count <= count;
        i_now_clock    <= now;
        do @(posedge i_clk); while (!o_in_ready);
        next_sector = sector + count;
        req_clock   = now;
        sent++;
        if (sent % 64 == 0)
            steady_send = ($urandom_range(0, 3) == 0);
    endtask

    // drop valid and hold until every delay word has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input int n);
        logic [31:0] sector;
        logic [15:0] count;
        logic [63:0] now;
        int          pick;
        repeat (n) begin
            pick  = $urandom_range(0, 99);
            count = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
            case ($urandom_range(0, 2))
                0:       now = req_clock + 64'($urandom_range(0, 3000));
                1:       now = req_clock + 64'($urandom_range(0, 800000));
                default: now = req_clock + 64'($urandom_range(0, 50000000));
            endcase
            if (pick < 60) begin
                sector = next_sector;
            end else if (pick < 75) begin
                sector = $urandom;
            end else if (pick < 87) begin
                case ($urandom_range(0, 8))
                    0:       sector = 32'd0;
                    1:       sector = 32'hFFFF_FFFF;
                    2:       sector = layer_start_cfg;
                    3:       sector = layer_start_cfg - 32'd1;
                    4:       sector = layer_start_cfg + 32'd1;
                    5:       sector = 32'd0 - CD_K2;
                    6:       sector = 32'd0 - SL_K2;
                    7:       sector = 32'd0 - DL_K2;
                    default: sector = layer_start_cfg - DL_K2;
                endcase
            end else begin
                // break the sequence by one sector, and now and then let the clock jump
                sector = ($urandom_range(0, 1) == 0) ? next_sector + 32'd1 : next_sector - 32'd1;
                if ($urandom_range(0, 1) == 0)
                    now = {$urandom, $urandom};
            end
            send_request(sector, count, now);
        end
    endtask

    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = steady_take ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
            if (taken % 50 == 0)
                steady_take = ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_top: no word moved for %0d cycles", QUIET_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-layer DVD
        set_media(1'b0, 32'd0);
        send_request(32'd0, 16'd1, 64'd1000);      // first request: end clock taken from now
        send_request(32'd1, 16'd16, req_clock + 64'd5000);
        send_request(32'd17, 16'hFFFF, req_clock + 64'd10_000_000);
        send_request(32'hFFFF_FFFF, 16'hFFFF, req_clock + 64'd777);
        send_request(32'd0 - SL_K2, 16'd1, req_clock + 64'd123);
        send_request(32'd5, 16'd0, 64'd0);          // leaves the end clock at zero
        send_request(32'd5, 16'd3, 64'hFFFF_FFFF_FFFF_FFF0);
        send_request(32'd8, 16'd1, 64'd100);        // clock runs backwards
        drain();

        // CD: plain, floored, and the all-ones quotient that the floor must not touch
        set_media(1'b1, 32'd0);
        send_request(next_sector, 16'd2, req_clock + 64'd40000);
        send_request(32'h1000_0000, 16'd4, req_clock + 64'd50);
        send_request(32'd0 - CD_K2, 16'd1, req_clock + 64'd9000);
        send_request(32'd0, 16'd9, req_clock + 64'd20);
        drain();

        // dual-layer DVD around the layer boundary
        set_media(1'b0, 32'h0010_0000);
        send_request(32'h000F_FFFF, 16'd1, req_clock + 64'd3000);
        send_request(32'h0010_0000, 16'd1, req_clock + 64'd60000);
        send_request(32'h0010_0001, 16'd300, req_clock + 64'd2);
        send_request(32'hFFFF_FFFF, 16'd7, req_clock + 64'd1_000_000);
        drain();
        set_media(1'b0, 32'd1);
        send_request(32'd1 - DL_K2, 16'd2, req_clock + 64'd500);
        drain();
        set_media(1'b0, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 16'd1, req_clock + 64'd4000);
        send_request(32'hFFFF_FFFE, 16'd1, req_clock + 64'd4000);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       set_media(1'b0, 32'd0);
                1:       set_media(1'b1, 32'd0);
                2:       set_media(1'b0, $urandom);
                3:       set_media(1'b1, $urandom);
                4:       set_media(1'b0, 32'hFFFF_FFFF);
                default: set_media(1'b0, 32'd1);
            endcase
            if (phase % 2 == 1)
                req_clock = {$urandom, $urandom};
            send_random(PHASE_ITEMS);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb_top: %0d read requests over %0d media settings, %0d delays compared",
                 sent, settings_run, checked);
        $display("tb_top: %0d requests took the sequential read-ahead path", credited);
        if (fail_count == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
